// ----- rtl/xyzkh_pkg.sv -----
// Shared types, constants and hash function for the xyz key hash table.
// Used by the RTL, the checker and the testbench; no dependencies.
`timescale 1ns / 1ps

package xyzkh_pkg;

  localparam int TABLE_SLOTS  = 1024;  // power of two
  localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
  localparam int COUNT_BITS   = SLOT_BITS + 1;
  localparam int VALUE_BITS   = 32;
  localparam int KEY_BITS     = 32;
  localparam int Y_SHIFT      = 10;
  localparam int Z_SHIFT      = 20;
  localparam int FILL_PERCENT = 66;
  localparam int FILL_SCALE   = 100;
  // count * FILL_SCALE > TABLE_SLOTS * FILL_PERCENT  <=>  count > FILL_LIMIT
  localparam int FILL_LIMIT   = (TABLE_SLOTS * FILL_PERCENT) / FILL_SCALE;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    FLAG_EMPTY = 2'd0,
    FLAG_USED  = 2'd1,
    FLAG_TOMB  = 2'd2
  } flag_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_e;

  typedef struct packed {
    flag_e                 flag;
    logic [KEY_BITS-1:0]   key_x;
    logic [KEY_BITS-1:0]   key_y;
    logic [KEY_BITS-1:0]   key_z;
    logic [VALUE_BITS-1:0] value;
  } slot_row_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    slot_row_t            row;
  } slot_wr_t;

  function automatic logic [SLOT_BITS-1:0] home_slot(
    input logic [KEY_BITS-1:0] x,
    input logic [KEY_BITS-1:0] y,
    input logic [KEY_BITS-1:0] z
  );
    logic [KEY_BITS-1:0] h;
    logic [KEY_BITS-1:0] mag;
    h   = x ^ (y << Y_SHIFT) ^ (z << Z_SHIFT);
    mag = h[KEY_BITS-1] ? (~h + KEY_BITS'(1)) : h;
    return mag[SLOT_BITS-1:0];
  endfunction

endpackage

// ----- rtl/xyzkh_slot_store.sv -----
// Slot memory: flag, key and value per slot, one write and one registered read port.
// Depends on xyzkh_pkg.
`timescale 1ns / 1ps

module xyzkh_slot_store (
  input  logic                          clk_i,
  input  xyzkh_pkg::slot_wr_t           wr_i,
  input  logic                          rd_en_i,
  input  logic [xyzkh_pkg::SLOT_BITS-1:0] rd_addr_i,
  output xyzkh_pkg::slot_row_t          rd_row_o
);

  xyzkh_pkg::slot_row_t mem [xyzkh_pkg::TABLE_SLOTS];
  xyzkh_pkg::slot_row_t rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

// ----- rtl/xyz_key_hash_table_unit.sv -----
// Top level of the xyz key hash table: probe sequencer, entry count, result register.
// Depends on xyzkh_pkg and xyzkh_slot_store.
// Lookup, insert, remove probe k slots (1 to TABLE_SLOTS, one per cycle on the single read
// port); the next word is accepted only after the result word has been registered.
// Clear all sweeps every slot. A waiting result word stalls both.
// After reset the same sweep runs with in_ready_o low.
`timescale 1ns / 1ps

module xyz_key_hash_table_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] key_x_i,
  input  logic signed [31:0] key_y_i,
  input  logic signed [31:0] key_z_i,
  input  logic [31:0]        new_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [31:0]        read_value_o,
  output logic [1:0]         status_o,
  output logic               over_fill_limit_o
);

  localparam int SB = xyzkh_pkg::SLOT_BITS;
  localparam int CB = xyzkh_pkg::COUNT_BITS;
  localparam logic [SB-1:0] LAST_SLOT = SB'(xyzkh_pkg::TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

  state_e                          state_q;
  xyzkh_pkg::func_e                func_q;
  logic [31:0]                     key_x_q, key_y_q, key_z_q;
  logic [xyzkh_pkg::VALUE_BITS-1:0] value_q;
  logic [xyzkh_pkg::VALUE_BITS-1:0] hit_value_q;
  logic [SB-1:0]                   idx_q;
  logic [SB-1:0]                   n_q;
  logic [SB-1:0]                   slot_q;
  logic                            present_q;
  logic                            has_free_q;
  logic                            clr_reply_q;
  logic [CB-1:0]                   count_q;
  logic [CB-1:0]                   count_d;

  logic                            out_valid_q;
  logic                            found_q;
  logic [31:0]                     read_value_q;
  xyzkh_pkg::status_e              status_q;
  logic                            over_fill_q;

  xyzkh_pkg::slot_wr_t             wr;
  logic                            rd_en;
  logic [SB-1:0]                   rd_addr;
  xyzkh_pkg::slot_row_t            rd_row;

  logic                            accept;
  logic                            is_hit, is_empty, is_tomb;
  logic                            done_go;
  logic                            ins_ok;
  xyzkh_pkg::status_e              status_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign done_go    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign is_empty = (rd_row.flag == xyzkh_pkg::FLAG_EMPTY);
  assign is_tomb  = (rd_row.flag == xyzkh_pkg::FLAG_TOMB);
  assign is_hit   = (rd_row.flag == xyzkh_pkg::FLAG_USED) && (rd_row.key_x == key_x_q) &&
                    (rd_row.key_y == key_y_q) && (rd_row.key_z == key_z_q);

  assign ins_ok = present_q || has_free_q;

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q + SB'(1);
    if (state_q == ST_IDLE) begin
      rd_en   = accept;
      rd_addr = xyzkh_pkg::home_slot(key_x_i, key_y_i, key_z_i);
    end else if (state_q == ST_PROBE) begin
      rd_en = 1'b1;
    end

    wr           = '0;
    wr.addr      = slot_q;
    wr.row.key_x = key_x_q;
    wr.row.key_y = key_y_q;
    wr.row.key_z = key_z_q;
    wr.row.value = value_q;
    wr.row.flag  = xyzkh_pkg::FLAG_USED;
    if (state_q == ST_CLEAR) begin
      wr.en       = 1'b1;
      wr.addr     = n_q;
      wr.row      = '0;
      wr.row.flag = xyzkh_pkg::FLAG_EMPTY;
    end else if (done_go) begin
      case (func_q)
        xyzkh_pkg::FUNC_INSERT: wr.en = ins_ok;
        xyzkh_pkg::FUNC_REMOVE: begin
          wr.en       = present_q;
          wr.row.flag = xyzkh_pkg::FLAG_TOMB;
        end
        default: wr.en = 1'b0;
      endcase
    end
  end

  // result and count update
  always_comb begin
    count_d  = count_q;
    status_d = xyzkh_pkg::STATUS_OK;
    case (func_q)
      xyzkh_pkg::FUNC_LOOKUP: begin
        if (!present_q) status_d = xyzkh_pkg::STATUS_MISS;
      end
      xyzkh_pkg::FUNC_INSERT: begin
        if (!ins_ok) status_d = xyzkh_pkg::STATUS_FULL;
        else if (!present_q) count_d = count_q + CB'(1);
      end
      xyzkh_pkg::FUNC_REMOVE: begin
        if (!present_q) status_d = xyzkh_pkg::STATUS_MISS;
        else if (count_q != '0) count_d = count_q - CB'(1);
      end
      default: status_d = xyzkh_pkg::STATUS_OK;
    endcase
  end

  xyzkh_slot_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      n_q         <= '0;
      clr_reply_q <= 1'b0;
      count_q     <= '0;
      present_q   <= 1'b0;
      has_free_q  <= 1'b0;
      out_valid_q <= 1'b0;
      func_q      <= xyzkh_pkg::FUNC_CLEAR;
    end else begin
      if (out_valid_q && out_ready_i && !done_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          n_q <= n_q + SB'(1);
          if (n_q == LAST_SLOT) begin
            state_q <= clr_reply_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            func_q     <= xyzkh_pkg::func_e'(func_i);
            key_x_q    <= key_x_i;
            key_y_q    <= key_y_i;
            key_z_q    <= key_z_i;
            value_q    <= new_value_i[xyzkh_pkg::VALUE_BITS-1:0];
            idx_q      <= rd_addr;
            n_q        <= '0;
            present_q  <= 1'b0;
            has_free_q <= 1'b0;
            if (xyzkh_pkg::func_e'(func_i) == xyzkh_pkg::FUNC_CLEAR) begin
              count_q     <= '0;
              clr_reply_q <= 1'b1;
              state_q     <= ST_CLEAR;
            end else begin
              state_q <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (is_hit) begin
            present_q   <= 1'b1;
            slot_q      <= idx_q;
            hit_value_q <= rd_row.value;
            state_q     <= ST_DONE;
          end else begin
            if ((is_empty || is_tomb) && !has_free_q) begin
              has_free_q <= 1'b1;
              slot_q     <= idx_q;
            end
            if (is_empty || n_q == LAST_SLOT) begin
              state_q <= ST_DONE;
            end
            idx_q <= idx_q + SB'(1);
            n_q   <= n_q + SB'(1);
          end
        end
        ST_DONE: begin
          if (done_go) begin
            count_q      <= count_d;
            out_valid_q  <= 1'b1;
            found_q      <= present_q;
            read_value_q <= (func_q == xyzkh_pkg::FUNC_LOOKUP && present_q) ?
                            32'(hit_value_q) : '0;
            status_q     <= status_d;
            over_fill_q  <= (count_d > CB'(xyzkh_pkg::FILL_LIMIT));
            clr_reply_q  <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign read_value_o      = read_value_q;
  assign status_o          = status_q;
  assign over_fill_limit_o = over_fill_q;

endmodule

// ----- sim/xyzkh_table_checker.sv -----
// Scoreboard for xyz_key_hash_table_unit: watches both channels, keeps its own
// copy of the table, predicts every result word and compares it field by field.
// Depends on xyzkh_pkg for types and sizes.
`timescale 1ns / 1ps

module xyzkh_table_checker
  import xyzkh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_x_i,
  input  logic [31:0] key_y_i,
  input  logic [31:0] key_z_i,
  input  logic [31:0] new_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [31:0] read_value_i,
  input  logic [1:0]  status_i,
  input  logic        over_fill_limit_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          op_count_o,
  output int          hit_count_o,
  output int          full_count_o,
  output int          peak_fill_o
);

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    status_e               status;
    logic                  over_fill;
  } reply_t;

  flag_e                 table_flag [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   table_x    [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   table_y    [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   table_z    [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] table_val  [TABLE_SLOTS];
  int                    fill = 0;
  reply_t                replies_due [$];
  reply_t                want;
  int                    fails = 0;
  int                    waiting = 0;
  int                    ops = 0;
  int                    hits = 0;
  int                    fulls = 0;
  int                    peak = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;
  assign op_count_o   = ops;
  assign hit_count_o  = hits;
  assign full_count_o = fulls;
  assign peak_fill_o  = peak;

  function automatic int unsigned home_of(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] h;
    h = x ^ (y << Y_SHIFT) ^ (z << Z_SHIFT);
    if (h[31]) h = 32'd0 - h;
    return h % TABLE_SLOTS;
  endfunction

  function automatic reply_t predict_reply(func_e f, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic [31:0] v);
    reply_t      r;
    int unsigned i;
    int          n;
    int          hit;
    int          spare;
    logic        stop;
    r.found      = 1'b0;
    r.read_value = '0;
    r.status     = STATUS_OK;
    hit          = -1;
    spare        = -1;
    if (f == FUNC_CLEAR) begin
      foreach (table_flag[k]) table_flag[k] = FLAG_EMPTY;
      fill = 0;
    end else begin
      i    = home_of(x, y, z);
      n    = 0;
      stop = 1'b0;
      // tombstones are skipped but remembered as the first free slot
      while (!stop && n < TABLE_SLOTS) begin
        if (table_flag[i] == FLAG_EMPTY) begin
          if (spare < 0) spare = i;
          stop = 1'b1;
        end else if (table_flag[i] == FLAG_TOMB) begin
          if (spare < 0) spare = i;
        end else if (table_x[i] == x && table_y[i] == y && table_z[i] == z) begin
          hit  = i;
          stop = 1'b1;
        end
        i = (i + 1) % TABLE_SLOTS;
        n++;
      end
      r.found = (hit >= 0);
      case (f)
        FUNC_LOOKUP: begin
          if (hit >= 0) r.read_value = table_val[hit];
          else r.status = STATUS_MISS;
        end
        FUNC_INSERT: begin
          if (hit >= 0) begin
            table_val[hit] = v[VALUE_BITS-1:0];
          end else if (spare >= 0) begin
            table_x[spare]    = x;
            table_y[spare]    = y;
            table_z[spare]    = z;
            table_val[spare]  = v[VALUE_BITS-1:0];
            table_flag[spare] = FLAG_USED;
            fill++;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        FUNC_REMOVE: begin
          if (hit >= 0) begin
            table_flag[hit] = FLAG_TOMB;
            if (fill > 0) fill--;
          end else begin
            r.status = STATUS_MISS;
          end
        end
        default: ;
      endcase
    end
    r.over_fill = (fill * FILL_SCALE) > (TABLE_SLOTS * FILL_PERCENT);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (table_flag[k]) table_flag[k] = FLAG_EMPTY;
      fill = 0;
      replies_due.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        want = predict_reply(func_e'(func_i), key_x_i, key_y_i, key_z_i, new_value_i);
        replies_due.push_back(want);
        ops++;
        if (func_e'(func_i) == FUNC_LOOKUP && want.found) hits++;
        if (want.status == STATUS_FULL) fulls++;
        if (fill > peak) peak = fill;
      end
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("result word with nothing outstanding");
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (found_i !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_i);
            fails++;
          end
          if (read_value_i !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fails++;
          end
          if (over_fill_limit_i !== want.over_fill) begin
            $error("over_fill_limit: expected %0d, got %0d", want.over_fill,
                   over_fill_limit_i);
            fails++;
          end
        end
      end
    end
    waiting = replies_due.size();
  end

endmodule

// ----- sim/xyz_key_hash_table_unit_tb.sv -----
// Testbench top for xyz_key_hash_table_unit: drives operation words, random stalls
// on both channels and gives the verdict. Depends on xyzkh_pkg, the DUT and the checker.
`timescale 1ns / 1ps

module xyz_key_hash_table_unit_tb;
  import xyzkh_pkg::*;

  localparam int STALL_LIMIT = 8 * TABLE_SLOTS;
  localparam int POOL_SIZE   = 40;
  localparam int MIXED_WORDS = 480;
  localparam int QUIET_TAIL  = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [31:0] key_x_i;
  logic [31:0] key_y_i;
  logic [31:0] key_z_i;
  logic [31:0] new_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        found_o;
  logic [31:0] read_value_o;
  logic [1:0]  status_o;
  logic        over_fill_limit_o;

  int fail_count, pending, op_count, hit_count, full_count, peak_fill;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int quiet_cycles = 0;

  logic [31:0] pool_x [POOL_SIZE];
  logic [31:0] pool_y [POOL_SIZE];
  logic [31:0] pool_z [POOL_SIZE];
  logic [31:0] fill_x [TABLE_SLOTS];
  logic [31:0] fill_y [TABLE_SLOTS];
  logic [31:0] fill_z [TABLE_SLOTS];
  int unsigned order  [TABLE_SLOTS];

  xyz_key_hash_table_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .key_x_i           (key_x_i),
    .key_y_i           (key_y_i),
    .key_z_i           (key_z_i),
    .new_value_i       (new_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .found_o           (found_o),
    .read_value_o      (read_value_o),
    .status_o          (status_o),
    .over_fill_limit_o (over_fill_limit_o)
  );

  xyzkh_table_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .func_i            (func_i),
    .key_x_i           (key_x_i),
    .key_y_i           (key_y_i),
    .key_z_i           (key_z_i),
    .new_value_i       (new_value_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .found_i           (found_o),
    .read_value_i      (read_value_o),
    .status_i          (status_o),
    .over_fill_limit_i (over_fill_limit_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .op_count_o        (op_count),
    .hit_count_o       (hit_count),
    .full_count_o      (full_count),
    .peak_fill_o       (peak_fill)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (recv_gap_pct > 0 && $urandom_range(0, 99) < recv_gap_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  // random key whose probe starts at the given slot
  task automatic aim_key(input int unsigned slot, output logic [31:0] x,
                         output logic [31:0] y, output logic [31:0] z);
    x = $urandom;
    y = $urandom;
    z = $urandom;
    if (x[31] ^ y[31-Y_SHIFT] ^ z[31-Z_SHIFT]) begin
      x[SLOT_BITS-1:0] = SLOT_BITS'(TABLE_SLOTS - slot);
    end else begin
      x[SLOT_BITS-1:0] = SLOT_BITS'(slot);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_word(input func_e f, input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic [31:0] v);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    func_i      = f;
    key_x_i     = x;
    key_y_i     = y;
    key_z_i     = z;
    new_value_i = v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic mixed_word;
    int unsigned pick;
    int unsigned roll;
    func_e       f;
    logic [31:0] x, y, z;
    pick = $urandom_range(0, POOL_SIZE - 1);
    x    = pool_x[pick];
    y    = pool_y[pick];
    z    = pool_z[pick];
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) f = FUNC_CLEAR;
    else if (roll < 40) f = FUNC_INSERT;
    else if (roll < 70) f = FUNC_LOOKUP;
    else f = FUNC_REMOVE;
    put_word(f, x, y, z, $urandom);
  endtask

  initial begin
    logic [31:0] nx, ny, nz;
    int unsigned s, t, tmp;
    func_e       f;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_LOOKUP;
    key_x_i     = '0;
    key_y_i     = '0;
    key_z_i     = '0;
    new_value_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, collisions, tombstones, wrap-around, clear
    send_gap_pct = 30;
    recv_gap_pct = 30;
    put_word(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_REMOVE, 32'h0, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_INSERT, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    put_word(FUNC_INSERT, 32'h8000_0000, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    put_word(FUNC_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 32'h5);
    put_word(FUNC_LOOKUP, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h5);
    put_word(FUNC_INSERT, 32'h0, 32'h0, 32'h0, 32'h1234_5678);
    put_word(FUNC_REMOVE, 32'h0, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_REMOVE, 32'h0, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_INSERT, TABLE_SLOTS, 32'h0, 32'h0, 32'ha5a5_a5a5);
    put_word(FUNC_INSERT, TABLE_SLOTS - 1, 32'h0, 32'h0, 32'h5a5a_5a5a);
    put_word(FUNC_INSERT, 2 * TABLE_SLOTS - 1, 32'h0, 32'h0, 32'h0f0f_0f0f);
    put_word(FUNC_LOOKUP, 2 * TABLE_SLOTS - 1, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hdead_beef);
    put_word(FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h1);
    put_word(FUNC_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    put_word(FUNC_LOOKUP, 2 * TABLE_SLOTS - 1, 32'h0, 32'h0, 32'h1);
    put_word(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    put_word(FUNC_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1);

    // mixed traffic over a small key set, half of it crowded round the wrap point
    for (int k = 0; k < POOL_SIZE; k++) begin
      if (k % 2 == 0) begin
        aim_key((TABLE_SLOTS - 4 + k % 8) % TABLE_SLOTS, pool_x[k], pool_y[k], pool_z[k]);
      end else begin
        pool_x[k] = $urandom;
        pool_y[k] = $urandom;
        pool_z[k] = $urandom;
      end
    end
    for (int n = 0; n < MIXED_WORDS; n++) begin
      if (n % 60 == 0) begin
        send_gap_pct = 20 * $urandom_range(0, 2);
        recv_gap_pct = 20 * $urandom_range(0, 2);
      end
      mixed_word();
    end

    // hold off until the table is quiet, then fill every slot
    drain();
    send_gap_pct = 25;
    recv_gap_pct = 25;
    put_word(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
    foreach (order[k]) order[k] = k;
    for (int k = TABLE_SLOTS - 1; k > 0; k--) begin
      t        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[t];
      order[t] = tmp;
    end
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      if (k == TABLE_SLOTS - QUIET_TAIL) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      s = order[k];
      aim_key(s, fill_x[s], fill_y[s], fill_z[s]);
      put_word(FUNC_INSERT, fill_x[s], fill_y[s], fill_z[s], $urandom);
    end

    // full table: refused insert, full-wrap misses, update, tombstone reuse
    aim_key($urandom_range(0, TABLE_SLOTS - 1), nx, ny, nz);
    put_word(FUNC_INSERT, nx, ny, nz, $urandom);
    put_word(FUNC_LOOKUP, nx, ny, nz, $urandom);
    put_word(FUNC_REMOVE, nx, ny, nz, $urandom);
    s = $urandom_range(0, TABLE_SLOTS - 1);
    put_word(FUNC_INSERT, fill_x[s], fill_y[s], fill_z[s], $urandom);
    put_word(FUNC_LOOKUP, fill_x[s], fill_y[s], fill_z[s], $urandom);
    put_word(FUNC_REMOVE, fill_x[s], fill_y[s], fill_z[s], $urandom);
    put_word(FUNC_LOOKUP, fill_x[s], fill_y[s], fill_z[s], $urandom);
    put_word(FUNC_INSERT, nx, ny, nz, $urandom);
    put_word(FUNC_LOOKUP, nx, ny, nz, $urandom);
    aim_key($urandom_range(0, TABLE_SLOTS - 1), nx, ny, nz);
    put_word(FUNC_INSERT, nx, ny, nz, $urandom);
    for (int n = 0; n < 20; n++) begin
      s = $urandom_range(0, TABLE_SLOTS - 1);
      t = $urandom_range(0, 2);
      if (t == 0) f = FUNC_LOOKUP;
      else if (t == 1) f = FUNC_INSERT;
      else f = FUNC_REMOVE;
      put_word(f, fill_x[s], fill_y[s], fill_z[s], $urandom);
    end
    put_word(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
    put_word(FUNC_LOOKUP, fill_x[s], fill_y[s], fill_z[s], $urandom);

    drain();
    repeat (64) @(negedge clk_i);
    $display("Ran %0d operations: %0d lookup hits, %0d refused inserts on a full table,",
             op_count, hit_count, full_count);
    $display("fill peaked at %0d of %0d slots.", peak_fill, TABLE_SLOTS);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- xyz_key_hash_table_unit.f -----
rtl/xyzkh_pkg.sv
rtl/xyzkh_slot_store.sv
rtl/xyz_key_hash_table_unit.sv
sim/xyzkh_table_checker.sv
sim/xyz_key_hash_table_unit_tb.sv
